// ===== sv/deq_pkg.sv =====
// deq_pkg: types and codes shared by the double-ended queue
// item and result structs, operation and status codes; no dependencies

package deq_pkg;

	// default geometry
	localparam int DEQ_DEPTH      = 16;
	localparam int DEQ_DATA_WIDTH = 32;

	// fixed field widths of the item and result
	localparam int KIND_W   = 2;
	localparam int ELEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ELEM_W-1:0] element;
	} deq_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
		logic [ELEM_W-1:0]   front_value;
		logic [ELEM_W-1:0]   back_value;
		logic                nonempty;
	} deq_out_t;

endpackage

// ===== sv/double_ended_queue_top.sv =====
// double_ended_queue_top: ring-buffer deque over a synchronous entry memory
// depends on deq_pkg for the item and result structs and the codes
//
// latency: the result of an item is strobed on done in the cycle after acceptance
// throughput: one item per cycle; busy is never raised, since the pointer update
// is a single increment or decrement and the result stage forwards the written word
// reset: queue empty (head, tail and count cleared); memory contents undefined,
// no clearing pass, only occupied entries are ever shown; receiver cannot stall

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEQ_DEPTH,
	parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  deq_in_t  item,
	output logic     done,
	output deq_out_t result
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// ring index steps with wrap
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	// entry memory
	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// pointer state: head is the front slot, tail the next free back slot
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             done_q;

	// result stage
	logic [STATUS_W-1:0]   status_s1;
	logic [CNT_W-1:0]      count_s1;
	logic [DATA_WIDTH-1:0] rd_front_s1, rd_back_s1, elem_s1;
	logic                  fwd_front_s1, fwd_back_s1;

	logic                  accept;
	logic [DATA_WIDTH-1:0] elem;
	logic [IDX_W-1:0]      head_n, tail_n, back_addr_n, wr_addr;
	logic [CNT_W-1:0]      count_n;
	logic                  wr_en;
	logic [STATUS_W-1:0]   status_n;
	logic                  is_full, is_empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign elem   = DATA_WIDTH'(item.element);

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	// operation decode and next pointers
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		wr_en    = 1'b0;
		wr_addr  = tail_q;
		status_n = ST_DONE;
		unique case (item.kind)
			KIND_PUSH_BACK: begin
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_q;
					tail_n  = idx_inc(tail_q);
					count_n = count_q + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					head_n  = idx_dec(head_q);
					wr_addr = head_n;
					count_n = count_q + 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					head_n  = idx_inc(head_q);
					count_n = count_q - 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					tail_n  = idx_dec(tail_q);
					count_n = count_q - 1'b1;
				end
			end
		endcase
		back_addr_n = idx_dec(tail_n);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
		end
	end

	// memory write and read of the new front and back slots
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= elem;
		end
		if (accept) begin
			rd_front_s1 <= mem[head_n];
			rd_back_s1  <= mem[back_addr_n];
		end
	end

	// result stage, with forwarding of the word written this item
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_n;
			count_s1     <= count_n;
			elem_s1      <= elem;
			fwd_front_s1 <= wr_en && (head_n == wr_addr);
			fwd_back_s1  <= wr_en && (back_addr_n == wr_addr);
		end
	end

	// result assembly
	logic                  nonempty_s1;
	logic [DATA_WIDTH-1:0] front_word, back_word;

	assign nonempty_s1 = (count_s1 != '0);
	assign front_word  = !nonempty_s1 ? '0 : (fwd_front_s1 ? elem_s1 : rd_front_s1);
	assign back_word   = !nonempty_s1 ? '0 : (fwd_back_s1 ? elem_s1 : rd_back_s1);

	assign done               = done_q;
	assign result.status      = status_s1;
	assign result.occupancy   = OCC_W'(count_s1);
	assign result.front_value = ELEM_W'(front_word);
	assign result.back_value  = ELEM_W'(back_word);
	assign result.nonempty    = nonempty_s1;

	// checks
	logic [CNT_W:0] head_plus_count;
	assign head_plus_count = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_tail_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(head_plus_count == (CNT_W + 1)'(tail_q)) ||
		(head_plus_count == (CNT_W + 1)'(tail_q) + (CNT_W + 1)'(DEPTH)))
		else $error("tail does not follow head plus count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_q)
		else $error("accepted item gave no result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_s1 == ST_FULL) |-> (count_s1 == FULL_CNT))
		else $error("push refused while queue not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_s1 == ST_EMPTY) |-> !nonempty_s1)
		else $error("pop refused while queue holds entries");

endmodule
